[src/swm_pkg.sv]
`timescale 1ns / 1ps

package swm_pkg;

  // Capacity and widths
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 7;

  // Input transaction: action in [1:0], value in [33:2], padded to whole bytes
  localparam int ACT_W     = 2;
  localparam int IN_BITS   = ACT_W + DATA_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Result transaction: mid_value, entry_count, removed_value, status
  localparam int STAT_W     = 2;
  localparam int OUT_BITS   = DATA_W + OUT_CNT_W + DATA_W + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Action codes (code 3 is unused and leaves the state alone)
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELMID = 2'd2
  } act_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic              push_en;  // write value into the cell just above the top
    logic              pop_en;   // drop the top cell
    logic              del_en;   // cells at or above the middle take from above
    logic              mid_up;   // middle marker moves one cell up
    logic              mid_down; // middle marker moves one cell down
    logic              rd_mid;   // read tap selects middle (else top)
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              occ;  // cell holds an entry
    logic              ge;   // cell index is at or above the middle
  } cell_link_t;

endpackage

[src/stack_with_middle_access.sv]
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit words with push, pop and delete-middle.
// The middle is the entry at floor((count-1)/2) from the bottom. Each entry
// lives in its own cell of a chain; a cell knows whether it is occupied and
// whether it sits at or above the middle, and takes data from its upper
// neighbor when the middle is deleted. The cells update in the accept cycle
// while the removed word is captured, and the new middle is then read from
// the cells into the output register once that register is free. A new
// transaction is taken once the previous result has moved into the output
// register. While one result waits there, the next transaction is still
// taken, but it then holds the input off until the output register frees.
// Full pushes and empty pops or deletes report status and change nothing.

module stack_with_middle_access
  import swm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // action [1:0], value [33:2]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mid_value [31:0], entry_count [38:32], removed_value [70:39], status [72:71]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // mid_valid [0]
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  logic [ACT_W-1:0]   in_act;
  logic [DATA_W-1:0]  in_value;
  logic               in_acc;
  logic               is_full, is_empty;
  cell_ctrl_t         ctrl;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               busy_r, busy_nxt;
  logic [DATA_W-1:0]  rem_r, rem_nxt;
  status_t            stat_r, stat_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_mid_r;
  logic                 out_mvld_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic [DATA_W-1:0]    out_rem_r;
  status_t              out_stat_r;
  logic                 out_load;

  cell_link_t         links [DEPTH];
  logic [DATA_W-1:0]  taps  [DEPTH];
  logic [DATA_W-1:0]  tap_or;

  assign in_act   = in_tdata[ACT_W-1:0];
  assign in_value = in_tdata[ACT_W +: DATA_W];
  assign in_tready = !busy_r;
  assign in_acc   = in_tvalid && in_tready;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Control broadcast to the cell chain
  always_comb begin
    ctrl          = '0;
    ctrl.value    = in_value;
    ctrl.push_en  = in_acc && (in_act == ACT_PUSH) && !is_full;
    ctrl.pop_en   = in_acc && (in_act == ACT_POP) && !is_empty;
    ctrl.del_en   = in_acc && (in_act == ACT_DELMID) && !is_empty;
    // push onto an even, non-empty stack moves the middle up
    ctrl.mid_up   = ctrl.push_en && !count_r[0] && !is_empty;
    // removal from an odd stack of three or more moves it down
    ctrl.mid_down = (ctrl.pop_en || ctrl.del_en) && count_r[0]
                    && (count_r != CNT_W'(1));
    ctrl.rd_mid   = busy_r || (in_act != ACT_POP);
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t lo, hi;
    if (i == 0) begin : g_bot
      assign lo = '{data: '0, occ: 1'b1, ge: 1'b0};
    end else begin : g_lo
      assign lo = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign hi = '{data: '0, occ: 1'b0, ge: 1'b1};
    end else begin : g_hi
      assign hi = links[i+1];
    end
    swm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .below  (lo),
      .above  (hi),
      .link   (links[i]),
      .rd_tap (taps[i])
    );
  end

  // One-hot read of the selected cell
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  // Accept stage: count, removed word, status
  always_comb begin
    count_nxt = count_r;
    rem_nxt   = rem_r;
    stat_nxt  = stat_r;
    busy_nxt  = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      stat_nxt = ST_OK;
      case (in_act)
        ACT_PUSH: begin
          if (is_full) stat_nxt = ST_FULL;
          else         count_nxt = count_r + CNT_W'(1);
        end
        ACT_POP, ACT_DELMID: begin
          if (is_empty) begin
            stat_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            rem_nxt   = tap_or;
          end
        end
        default: ;
      endcase
    end else if (busy_r && out_load) begin
      busy_nxt = 1'b0;
    end
  end

  // Result stage
  assign out_load = busy_r && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      out_mid_r  <= is_empty ? '0 : tap_or;
      out_mvld_r <= !is_empty;
      out_cnt_r  <= OUT_CNT_W'(count_r);
      out_rem_r  <= rem_r;
      out_stat_r <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_mvld_r;
  assign out_tdata  = OUT_TDATA_W'({out_stat_r, out_rem_r, out_cnt_r, out_mid_r});

endmodule

[src/swm_cell.sv]
`timescale 1ns / 1ps

module swm_cell
  import swm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  cell_link_t          below,
  input  cell_link_t          above,
  output cell_link_t          link,
  output logic [DATA_W-1:0]   rd_tap
);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              occ_r, occ_nxt;
  logic              ge_r, ge_nxt;
  logic              is_mid, is_top;

  // Position markers derived from the neighbors
  assign is_mid = ge_r & ~below.ge;
  assign is_top = occ_r & ~above.occ;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    ge_nxt   = ge_r;

    // occupancy: grow from below on push, shrink from above on pop/delete
    if (ctrl.push_en) begin
      occ_nxt = occ_r | below.occ;
      if (below.occ && !occ_r) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.pop_en || ctrl.del_en) begin
      occ_nxt = above.occ;
    end

    // close the gap left by the deleted middle
    if (ctrl.del_en && ge_r) begin
      data_nxt = above.data;
    end

    // middle marker boundary
    if (ctrl.mid_up) begin
      ge_nxt = below.ge;
    end else if (ctrl.mid_down) begin
      ge_nxt = above.ge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      ge_r  <= 1'b1;
    end else begin
      occ_r <= occ_nxt;
      ge_r  <= ge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link.data = data_r;
  assign link.occ  = occ_r;
  assign link.ge   = ge_r;

  assign rd_tap = data_r & {DATA_W{ctrl.rd_mid ? is_mid : is_top}};

endmodule

[tb/stack_with_middle_access_tb.sv]
`timescale 1ns / 1ps

module stack_with_middle_access_tb;
  import swm_pkg::*;

  // Unused action code: the block leaves its state alone
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  // Result field offsets inside out_tdata
  localparam int OFS_CNT = DATA_W;
  localparam int OFS_REM = DATA_W + OUT_CNT_W;
  localparam int OFS_ST  = DATA_W + OUT_CNT_W + DATA_W;

  localparam int IDLE_MAX       = 18;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [DATA_W-1:0]    mid_value;
    logic                 mid_valid;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [DATA_W-1:0]    removed_value;
    status_t              status;
  } stack_result_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;

  stack_with_middle_access dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow stack, the expected results in order, and run statistics
  logic [DATA_W-1:0] shadow_stack [DEPTH];
  int unsigned       shadow_fill;
  stack_result_t     expected_results [$];

  int unsigned n_ops;
  int unsigned n_results;
  int unsigned n_mismatch;
  int unsigned n_full_push;
  int unsigned n_empty_op;
  int unsigned n_unused_op;
  int unsigned n_mid_delete;
  int unsigned n_full_reached;

  int tx_idle_max;
  int rx_idle_max;
  bit rx_hold_req;

  // Apply one operation to the shadow stack and return the result it causes
  function automatic stack_result_t stack_predict(input logic [ACT_W-1:0] act,
                                                  input logic [DATA_W-1:0] value);
    stack_result_t res;
    int unsigned   m;
    res = '0;
    res.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
          n_full_push++;
        end else begin
          shadow_stack[shadow_fill] = value;
          shadow_fill++;
          if (shadow_fill == DEPTH) n_full_reached++;
        end
      end
      ACT_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
          n_empty_op++;
        end else begin
          shadow_fill--;
          res.removed_value = shadow_stack[shadow_fill];
        end
      end
      ACT_DELMID: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
          n_empty_op++;
        end else begin
          m = (shadow_fill - 1) / 2;
          res.removed_value = shadow_stack[m];
          for (int unsigned i = m; i + 1 < shadow_fill; i++)
            shadow_stack[i] = shadow_stack[i + 1];
          shadow_fill--;
          n_mid_delete++;
        end
      end
      default: n_unused_op++;
    endcase
    if (shadow_fill > 0) begin
      res.mid_value = shadow_stack[(shadow_fill - 1) / 2];
      res.mid_valid = 1'b1;
    end
    res.entry_count = shadow_fill[OUT_CNT_W-1:0];
    return res;
  endfunction

  // Send one operation; the shadow stack is updated when it is accepted
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] value);
    int gap;
    gap = (tx_idle_max > 0) ? $urandom_range(0, tx_idle_max) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, value, act};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(stack_predict(act, value));
    n_ops++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Withdraw the last transaction first so it is not taken twice
  task automatic wait_drained();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Random operation, biased toward push by push_pct percent
  function automatic logic [ACT_W-1:0] rand_action(input int push_pct);
    if ($urandom_range(0, 99) < 3) return ACT_NOP;
    if ($urandom_range(0, 99) < push_pct) return ACT_PUSH;
    return $urandom_range(0, 1) ? ACT_POP : ACT_DELMID;
  endfunction

  function automatic int rand_idle_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return IDLE_MAX;
    endcase
  endfunction

  // Receiver: random ready gaps, or one long hold when asked
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req) begin
        gap = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        gap = (rx_idle_max > 0) ? $urandom_range(0, rx_idle_max) : 0;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      got.mid_value     = out_tdata[DATA_W-1:0];
      got.mid_valid     = out_tuser;
      got.entry_count   = out_tdata[OFS_CNT +: OUT_CNT_W];
      got.removed_value = out_tdata[OFS_REM +: DATA_W];
      got.status        = status_t'(out_tdata[OFS_ST +: STAT_W]);
      n_results++;
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("%0t: result with nothing expected: mid=%h valid=%b cnt=%0d rem=%h st=%0d",
                   $realtime, got.mid_value, got.mid_valid, got.entry_count,
                   got.removed_value, got.status);
      end else begin
        exp = expected_results.pop_front();
        if (got.mid_value !== exp.mid_value || got.mid_valid !== exp.mid_valid ||
            got.entry_count !== exp.entry_count ||
            got.removed_value !== exp.removed_value || got.status !== exp.status) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("%0t: result %0d mismatch", $realtime, n_results);
            $display("  expected mid=%h valid=%b cnt=%0d rem=%h st=%0d", exp.mid_value,
                     exp.mid_valid, exp.entry_count, exp.removed_value, exp.status);
            $display("  actual   mid=%h valid=%b cnt=%0d rem=%h st=%0d", got.mid_value,
                     got.mid_valid, got.entry_count, got.removed_value, got.status);
          end
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("stack_with_middle_access verification failed");
    $finish;
  end

  // Operations on an empty stack
  task automatic test_empty_stack();
    send_op(ACT_POP, 32'h1234_5678);
    send_op(ACT_DELMID, 32'hffff_ffff);
    send_op(ACT_NOP, 32'h8000_0000);
  endtask

  // A stack of one entry: delete-middle and pop both empty it
  task automatic test_single_entry();
    send_op(ACT_PUSH, 32'h7fff_ffff);
    send_op(ACT_DELMID, 32'h0);
    send_op(ACT_PUSH, 32'h8000_0000);
    send_op(ACT_POP, 32'h0);
    send_op(ACT_PUSH, 32'h0);
    send_op(ACT_NOP, 32'hffff_ffff);
    send_op(ACT_DELMID, 32'h5555_5555);
  endtask

  // Middle moves and gap closing on a few entries
  task automatic test_middle_shift();
    send_op(ACT_PUSH, 32'hffff_ffff);
    send_op(ACT_PUSH, 32'h5555_5555);
    send_op(ACT_PUSH, 32'haaaa_aaaa);
    send_op(ACT_PUSH, 32'h8000_0000);
    send_op(ACT_PUSH, 32'h7fff_ffff);
    send_op(ACT_DELMID, 32'h0);
    send_op(ACT_NOP, 32'h0);
    send_op(ACT_DELMID, 32'h0);
    send_op(ACT_POP, 32'h0);
    send_op(ACT_DELMID, 32'h0);
    send_op(ACT_POP, 32'h0);
    send_op(ACT_POP, 32'h0);
  endtask

  // Fill to capacity, push when full, then drain to empty
  task automatic test_full_boundary();
    tx_idle_max = 0;
    rx_idle_max = 0;
    while (shadow_fill < DEPTH) send_op(ACT_PUSH, rand_word());
    send_op(ACT_PUSH, rand_word());
    send_op(ACT_NOP, rand_word());
    send_op(ACT_PUSH, rand_word());
    send_op(ACT_DELMID, rand_word());
    send_op(ACT_PUSH, rand_word());
    send_op(ACT_POP, rand_word());
    tx_idle_max = 4;
    rx_idle_max = 4;
    while (shadow_fill > 0)
      send_op($urandom_range(0, 1) ? ACT_POP : ACT_DELMID, rand_word());
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    wait_drained();
    tx_idle_max = 0;
    rx_idle_max = 0;
    rx_hold_req = 1'b1;
    repeat (30) send_op(rand_action(60), rand_word());
  endtask

  // Sender pauses until all results are back, then resumes
  task automatic test_drain_pause();
    tx_idle_max = rand_idle_max();
    rx_idle_max = rand_idle_max();
    repeat (20) send_op(rand_action(50), rand_word());
    wait_drained();
    repeat (20) send_op(rand_action(50), rand_word());
  endtask

  // Random walk of depth; segments vary push bias and idling on both sides
  task automatic test_random_walk(input int n_items);
    int push_pct;
    int done;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 20;
        1:       push_pct = 50;
        2:       push_pct = 80;
        default: push_pct = 95;
      endcase
      tx_idle_max = rand_idle_max();
      rx_idle_max = rand_idle_max();
      repeat (50) begin
        send_op(rand_action(push_pct), rand_word());
        done++;
      end
    end
  endtask

  // Test sequence
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    tx_idle_max = 0;
    rx_idle_max = 0;
    rx_hold_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_stack();
    test_single_entry();
    test_middle_shift();
    test_full_boundary();
    test_backpressure();
    test_drain_pause();
    test_random_walk(1000);

    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d operations, checked %0d results, %0d mismatches", n_ops, n_results,
             n_mismatch);
    $display("stack full %0d times, %0d full pushes, %0d empty pops/deletes, %0d middle deletes",
             n_full_reached, n_full_push, n_empty_op, n_mid_delete);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("stack_with_middle_access verification clean");
    end else begin
      $display("stack_with_middle_access verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/swm_pkg.sv
src/swm_cell.sv
src/stack_with_middle_access.sv
tb/stack_with_middle_access_tb.sv
